// ----- rtl/vvpd_pkg.sv -----
package vvpd_pkg;

  typedef enum logic [2:0] {
    PH_FIXED    = 3'd0,
    PH_TIME     = 3'd1,
    PH_INTERVAL = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_BODY     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic [7:0] ERR_MARK    = 8'd1;
  localparam logic [7:0] ERR_VERSION = 8'd2;
  localparam logic [7:0] ERR_PTYPE   = 8'd3;
  localparam logic [7:0] ERR_DTYPE   = 8'd4;
  localparam logic [7:0] ERR_SPLIT   = 8'd5;
  localparam logic [7:0] ERR_LENGTH  = 8'd6;

  localparam logic CFG_HEAD_MARK = 1'b0;
  localparam logic CFG_MAX_LEN   = 1'b1;

  localparam int QDEPTH = 2;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [7:0]  marker_and_type;
    logic [15:0] seq_number;
    logic [47:0] sim_bcd;
    logic [7:0]  channel;
    logic [7:0]  type_and_split;
    logic [63:0] time_stamp;
    logic [15:0] key_interval;
    logic [15:0] frame_interval;
    logic [15:0] body_length;
  } result_t;

  function automatic logic payload_ok(input logic [6:0] pt);
    return pt == 7'd6 || pt == 7'd7 || pt == 7'd8 || pt == 7'd26 ||
           pt == 7'd91 || pt == 7'd98;
  endfunction

endpackage

// ----- rtl/vvpd_parse.sv -----
module vvpd_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_vld,
  input  logic [7:0]         byte_in,
  input  logic [31:0]        head_mark,
  input  logic [15:0]        max_body_len,
  output logic               res_vld,
  output vvpd_pkg::result_t  res
);
  import vvpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] left_r, left_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic [7:0]  mt_r, mt_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [47:0] sim_r, sim_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [7:0]  ts_r, ts_nxt;
  logic [63:0] time_r, time_nxt;
  logic [15:0] key_r, key_nxt;
  logic [15:0] frm_r, frm_nxt;
  logic [15:0] len_r, len_nxt;
  logic [4:0]  pos_inc;
  logic [31:0] mark_sh;
  logic [15:0] len_sh;
  logic [15:0] left_dec;

  assign pos_inc  = pos_r + 5'd1;
  assign mark_sh  = {mark_r[23:0], byte_in};
  assign len_sh   = {len_r[7:0], byte_in};
  assign left_dec = (left_r != 16'd0) ? left_r - 16'd1 : 16'd0;

  // byte parser: capture fields, run the header checks and pass body bytes through
  always_comb begin
    phase_nxt = phase_r; pos_nxt = pos_r; left_nxt = left_r; mark_nxt = mark_r;
    mt_nxt = mt_r; seq_nxt = seq_r; sim_nxt = sim_r; ch_nxt = ch_r; ts_nxt = ts_r;
    time_nxt = time_r; key_nxt = key_r; frm_nxt = frm_r; len_nxt = len_r;
    res_vld = 1'b0;
    res = '0;
    if (byte_vld) begin
      unique case (phase_r)
        PH_BODY: begin
          res_vld = 1'b1;
          res.kind = KIND_BODY;
          res.data_byte = byte_in;
          res.last = (left_dec == 16'd0);
          left_nxt = left_dec;
          if (left_dec == 16'd0) phase_nxt = PH_FIXED;
        end
        PH_FIXED: begin
          pos_nxt = pos_inc;
          if (pos_r <= 5'd3) begin
            mark_nxt = mark_sh;
            if (pos_r == 5'd3 && mark_sh != head_mark) begin
              res_vld = 1'b1; res.kind = KIND_ERROR; res.data_byte = ERR_MARK;
            end
          end else if (pos_r == 5'd4) begin
            if (byte_in != 8'h81) begin
              res_vld = 1'b1; res.kind = KIND_ERROR; res.data_byte = ERR_VERSION;
            end
          end else if (pos_r == 5'd5) begin
            mt_nxt = byte_in;
            if (!payload_ok(byte_in[6:0])) begin
              res_vld = 1'b1; res.kind = KIND_ERROR; res.data_byte = ERR_PTYPE;
            end
          end else if (pos_r <= 5'd7) begin
            seq_nxt = {seq_r[7:0], byte_in};
          end else if (pos_r <= 5'd13) begin
            sim_nxt = {sim_r[39:0], byte_in};
          end else if (pos_r == 5'd14) begin
            ch_nxt = byte_in;
          end else begin
            ts_nxt = byte_in;
            pos_nxt = 5'd0;
            if (byte_in[7:4] > 4'd4) begin
              res_vld = 1'b1; res.kind = KIND_ERROR; res.data_byte = ERR_DTYPE;
            end else if (byte_in[3:0] > 4'd3) begin
              res_vld = 1'b1; res.kind = KIND_ERROR; res.data_byte = ERR_SPLIT;
            end else begin
              phase_nxt = (byte_in[7:4] == 4'd4) ? PH_LENGTH : PH_TIME;
            end
          end
        end
        PH_TIME: begin
          time_nxt = {time_r[55:0], byte_in};
          pos_nxt = pos_inc;
          if (pos_inc >= 5'd8) begin
            pos_nxt = 5'd0;
            phase_nxt = (ts_r[7:4] <= 4'd2) ? PH_INTERVAL : PH_LENGTH;
          end
        end
        PH_INTERVAL: begin
          if (pos_r < 5'd2) key_nxt = {key_r[7:0], byte_in};
          else              frm_nxt = {frm_r[7:0], byte_in};
          pos_nxt = pos_inc;
          if (pos_inc >= 5'd4) begin
            pos_nxt = 5'd0;
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_nxt = len_sh;
          pos_nxt = pos_inc;
          if (pos_inc >= 5'd2) begin
            res_vld = 1'b1;
            if (len_sh > max_body_len) begin
              res.kind = KIND_ERROR; res.data_byte = ERR_LENGTH;
            end else begin
              res.kind = KIND_HEADER;
              res.last = (len_sh == 16'd0);
              res.marker_and_type = mt_r;
              res.seq_number = seq_r;
              res.sim_bcd = sim_r;
              res.channel = ch_r;
              res.type_and_split = ts_r;
              res.time_stamp = time_r;
              res.key_interval = key_r;
              res.frame_interval = frm_r;
              res.body_length = len_sh;
              if (len_sh != 16'd0) begin
                phase_nxt = PH_BODY;
                left_nxt = len_sh;
                pos_nxt = 5'd0;
              end
            end
          end
        end
        default: phase_nxt = PH_FIXED;
      endcase
      // any error or finished packet restarts the header
      if ((res_vld && res.kind == KIND_ERROR) ||
          (res_vld && res.last) || phase_r > PH_BODY) begin
        phase_nxt = PH_FIXED; pos_nxt = 5'd0; left_nxt = '0; mark_nxt = '0;
        mt_nxt = '0; seq_nxt = '0; sim_nxt = '0; ch_nxt = '0; ts_nxt = '0;
        time_nxt = '0; key_nxt = '0; frm_nxt = '0; len_nxt = '0;
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED; pos_r <= '0; left_r <= '0; mark_r <= '0;
      mt_r <= '0; seq_r <= '0; sim_r <= '0; ch_r <= '0; ts_r <= '0;
      time_r <= '0; key_r <= '0; frm_r <= '0; len_r <= '0;
    end else begin
      phase_r <= phase_nxt; pos_r <= pos_nxt; left_r <= left_nxt;
      mark_r <= mark_nxt; mt_r <= mt_nxt; seq_r <= seq_nxt; sim_r <= sim_nxt;
      ch_r <= ch_nxt; ts_r <= ts_nxt; time_r <= time_nxt; key_r <= key_nxt;
      frm_r <= frm_nxt; len_r <= len_nxt;
    end
  end

  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> left_r != 16'd0)
    else $error("body phase with nothing left");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LENGTH |-> pos_r <= 5'd1)
    else $error("length position out of range");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && res_vld && res.kind == KIND_ERROR |=> phase_r == PH_FIXED && pos_r == 5'd0)
    else $error("no restart after error");
endmodule

// ----- rtl/vvpd_queue.sv -----
module vvpd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_vld,
  input  vvpd_pkg::result_t  wr_data,
  output logic               full,
  output logic               rd_vld,
  output vvpd_pkg::result_t  rd_data,
  input  logic               rd_stall
);
  import vvpd_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  result_t        mem_r [QDEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_rd, do_wr;

  assign full    = (cnt_r == (AW+1)'(QDEPTH));
  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign do_rd   = rd_vld && !rd_stall;
  assign do_wr   = wr_vld;

  // payload storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_rd |-> !do_wr)
    else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(QDEPTH))
    else $error("count out of range");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 && !do_wr |=> !rd_vld)
    else $error("valid from empty queue");
endmodule

// ----- rtl/vehicle_video_packet_deframer.sv -----
// channel | dir | handshake              | payload
// in      | in  | in_valid / in_stall    | in_byte
// out     | out | out_valid / out_stall  | kind .. body_length
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// one byte a cycle while in_stall is low; a result enters a two-entry queue the cycle its byte is taken
// and may leave the next cycle
// in_stall rises only while the queue is full and not draining
// reset (synchronous) restores defaults and restarts header parsing
module vehicle_video_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic [7:0]  out_marker_and_type,
  output logic [15:0] out_seq_number,
  output logic [47:0] out_sim_bcd,
  output logic [7:0]  out_channel,
  output logic [7:0]  out_type_and_split,
  output logic [63:0] out_time_stamp,
  output logic [15:0] out_key_interval,
  output logic [15:0] out_frame_interval,
  output logic [15:0] out_body_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import vvpd_pkg::*;

  logic [31:0] head_mark_r;
  logic [15:0] max_len_r;
  logic        full, acc, res_vld;
  result_t     res, q;

  assign cfg_ready = 1'b1;
  assign in_stall  = full && out_stall;
  assign acc       = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_mark_r <= 32'h3031_6364;
      max_len_r   <= 16'd950;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEAD_MARK: head_mark_r <= cfg_data;
        CFG_MAX_LEN:   max_len_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  vvpd_parse u_parse (
    .clk, .rst_n, .byte_vld(acc), .byte_in(in_in_byte),
    .head_mark(head_mark_r), .max_body_len(max_len_r), .res_vld, .res
  );

  vvpd_queue u_queue (
    .clk, .rst_n, .wr_vld(res_vld), .wr_data(res), .full,
    .rd_vld(out_valid), .rd_data(q), .rd_stall(out_stall)
  );

  assign out_kind            = q.kind;
  assign out_data_byte       = q.data_byte;
  assign out_last            = q.last;
  assign out_marker_and_type = q.marker_and_type;
  assign out_seq_number      = q.seq_number;
  assign out_sim_bcd         = q.sim_bcd;
  assign out_channel         = q.channel;
  assign out_type_and_split  = q.type_and_split;
  assign out_time_stamp      = q.time_stamp;
  assign out_key_interval    = q.key_interval;
  assign out_frame_interval  = q.frame_interval;
  assign out_body_length     = q.body_length;
endmodule

// ----- bench/testbench.sv -----
// expected-result store and checker for the packet deframer
class deframe_scoreboard;
  vvpd_pkg::result_t pending[$];
  int errors;

  // queue the result predicted for an accepted byte
  function void note_input(vvpd_pkg::result_t r);
    pending.push_back(r);
  endfunction

  // compare one result item with the oldest prediction, field by field
  task check_result(vvpd_pkg::result_t got);
    vvpd_pkg::result_t exp_r;
    if (pending.size() == 0) begin
      report("unexpected result", 64'(got.kind), 64'(0));
      return;
    end
    exp_r = pending.pop_front();
    if (got.kind != exp_r.kind) report("kind", got.kind, exp_r.kind);
    if (got.data_byte != exp_r.data_byte) report("data_byte", got.data_byte, exp_r.data_byte);
    if (got.last != exp_r.last) report("last", got.last, exp_r.last);
    if (got.marker_and_type != exp_r.marker_and_type)
      report("marker_and_type", got.marker_and_type, exp_r.marker_and_type);
    if (got.seq_number != exp_r.seq_number)
      report("seq_number", got.seq_number, exp_r.seq_number);
    if (got.sim_bcd != exp_r.sim_bcd) report("sim_bcd", got.sim_bcd, exp_r.sim_bcd);
    if (got.channel != exp_r.channel) report("channel", got.channel, exp_r.channel);
    if (got.type_and_split != exp_r.type_and_split)
      report("type_and_split", got.type_and_split, exp_r.type_and_split);
    if (got.time_stamp != exp_r.time_stamp)
      report("time_stamp", got.time_stamp, exp_r.time_stamp);
    if (got.key_interval != exp_r.key_interval)
      report("key_interval", got.key_interval, exp_r.key_interval);
    if (got.frame_interval != exp_r.frame_interval)
      report("frame_interval", got.frame_interval, exp_r.frame_interval);
    if (got.body_length != exp_r.body_length)
      report("body_length", got.body_length, exp_r.body_length);
  endtask

  // one line per mismatch, and count it
  task report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %0h expected %0h", field, got, want);
    errors++;
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vvpd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic [7:0]  out_marker_and_type;
  logic [15:0] out_seq_number;
  logic [47:0] out_sim_bcd;
  logic [7:0]  out_channel;
  logic [7:0]  out_type_and_split;
  logic [63:0] out_time_stamp;
  logic [15:0] out_key_interval;
  logic [15:0] out_frame_interval;
  logic [15:0] out_body_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_HEAD_MARK;
  logic [31:0] cfg_data = '0;

  vehicle_video_packet_deframer dut (.*);

  always #5 clk = ~clk;

  deframe_scoreboard board = new();

  // predictor state
  logic [31:0] mark_cfg;
  logic [15:0] max_len_cfg;
  phase_t      ph;
  logic [4:0]  pos;
  logic [15:0] left;
  logic [31:0] h_mark;
  result_t     h;

  int  items_sent;
  bit  calm;
  int  cycles;
  int  in_gap;
  int  out_gap;

  function automatic result_t plain(kind_t k, logic [7:0] d, logic l);
    result_t r;
    r = '0;
    r.kind = k;
    r.data_byte = d;
    r.last = l;
    return r;
  endfunction

  function automatic void restart_header();
    ph = PH_FIXED;
    pos = '0;
    left = '0;
    h_mark = '0;
    h = '0;
  endfunction

  // one byte through the deframer; pushes a prediction when a result is due
  function automatic void predict_byte(logic [7:0] b);
    logic [4:0] p;
    logic [3:0] dt;
    case (ph)
      PH_BODY: begin
        if (left > 0) left--;
        board.note_input(plain(KIND_BODY, b, left == 0));
        if (left == 0) restart_header();
      end
      PH_FIXED: begin
        p = pos;
        pos = p + 5'd1;
        if (p <= 3) begin
          h_mark = {h_mark[23:0], b};
          if (p == 3 && h_mark != mark_cfg) begin
            board.note_input(plain(KIND_ERROR, ERR_MARK, 1'b0));
            restart_header();
          end
        end else if (p == 4) begin
          if (b[7:6] != 2'd2 || b[5] || b[4] || b[3:0] != 4'd1) begin
            board.note_input(plain(KIND_ERROR, ERR_VERSION, 1'b0));
            restart_header();
          end
        end else if (p == 5) begin
          h.marker_and_type = b;
          if (!(b[6:0] inside {7'd6, 7'd7, 7'd8, 7'd26, 7'd91, 7'd98})) begin
            board.note_input(plain(KIND_ERROR, ERR_PTYPE, 1'b0));
            restart_header();
          end
        end else if (p <= 7) begin
          h.seq_number = {h.seq_number[7:0], b};
        end else if (p <= 13) begin
          h.sim_bcd = {h.sim_bcd[39:0], b};
        end else if (p == 14) begin
          h.channel = b;
        end else begin
          h.type_and_split = b;
          dt = b[7:4];
          if (dt > 4) begin
            board.note_input(plain(KIND_ERROR, ERR_DTYPE, 1'b0));
            restart_header();
          end else if (b[3:0] > 3) begin
            board.note_input(plain(KIND_ERROR, ERR_SPLIT, 1'b0));
            restart_header();
          end else begin
            pos = '0;
            ph = (dt == 4) ? PH_LENGTH : PH_TIME;
          end
        end
      end
      PH_TIME: begin
        h.time_stamp = {h.time_stamp[55:0], b};
        pos++;
        if (pos >= 8) begin
          pos = '0;
          ph = (h.type_and_split[7:4] <= 2) ? PH_INTERVAL : PH_LENGTH;
        end
      end
      PH_INTERVAL: begin
        if (pos < 2) h.key_interval = {h.key_interval[7:0], b};
        else h.frame_interval = {h.frame_interval[7:0], b};
        pos++;
        if (pos >= 4) begin
          pos = '0;
          ph = PH_LENGTH;
        end
      end
      default: begin
        h.body_length = {h.body_length[7:0], b};
        pos++;
        if (pos >= 2) begin
          if (h.body_length > max_len_cfg) begin
            board.note_input(plain(KIND_ERROR, ERR_LENGTH, 1'b0));
            restart_header();
          end else begin
            h.kind = KIND_HEADER;
            h.data_byte = '0;
            h.last = (h.body_length == 0);
            board.note_input(h);
            if (h.body_length == 0) restart_header();
            else begin
              left = h.body_length;
              ph = PH_BODY;
              pos = '0;
            end
          end
        end
      end
    endcase
  endfunction

  // drive one byte, with an optional idle burst before it
  task automatic send_byte(logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b);
    items_sent++;
  endtask

  task automatic send_field(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(v[i*8 +: 8]);
  endtask

  // a full packet; flaw selects which field (if any) is broken
  task automatic send_packet(int flaw, logic [3:0] dt, logic [15:0] blen);
    logic [6:0] pts[6];
    logic [7:0] mt;
    logic [7:0] ts;
    pts = '{7'd6, 7'd7, 7'd8, 7'd26, 7'd91, 7'd98};
    send_field(flaw == 1 ? mark_cfg ^ (32'h1 << $urandom_range(0, 31)) : mark_cfg, 4);
    if (flaw == 1) return;
    send_byte(flaw == 2 ? 8'h81 ^ (8'h1 << $urandom_range(0, 7)) : 8'h81);
    if (flaw == 2) return;
    mt = {1'($urandom), pts[$urandom_range(0, 5)]};
    if (flaw == 3) mt[6:0] = 7'($urandom_range(27, 90));
    send_byte(mt);
    if (flaw == 3) return;
    send_field({$urandom, $urandom}, 8);
    send_byte(8'($urandom));
    ts = {dt, 4'($urandom_range(0, 3))};
    if (flaw == 4) ts[7:4] = 4'($urandom_range(5, 15));
    if (flaw == 5) ts[3:0] = 4'($urandom_range(4, 15));
    send_byte(ts);
    if (flaw == 4 || flaw == 5) return;
    if (dt != 4) send_field({$urandom, $urandom}, 8);
    if (dt <= 2) send_field($urandom, 4);
    send_field(blen, 2);
    if (flaw == 6 || blen > max_len_cfg) return;
    for (int i = 0; i < blen; i++) send_byte(8'($urandom));
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HEAD_MARK) mark_cfg = v;
    else max_len_cfg = v[15:0];
  endtask

  // result side: random stalls and checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_kind, out_data_byte, out_last, out_marker_and_type,
                          out_seq_number, out_sim_bcd, out_channel, out_type_and_split,
                          out_time_stamp, out_key_interval, out_frame_interval,
                          out_body_length});
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int flaw;
    int settings;
    logic [15:0] blen;
    cycles = 0;
    out_gap = 0;
    calm = 0;
    items_sent = 0;
    mark_cfg = 32'h30316364;
    max_len_cfg = 16'd950;
    restart_header();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: data types 0, 3 and 4, each error, empty body, extreme bytes
    send_packet(0, 4'd4, 16'd0);
    send_packet(1, 4'd0, 16'd1);
    send_packet(2, 4'd0, 16'd1);
    send_packet(3, 4'd0, 16'd1);
    send_packet(4, 4'd0, 16'd1);
    send_packet(5, 4'd0, 16'd1);
    send_packet(6, 4'd0, 16'd951);
    send_packet(0, 4'd0, 16'd2);
    send_packet(0, 4'd3, 16'd1);
    send_byte(8'hff);
    send_byte(8'h00);
    drain();

    // random phases across register settings
    for (settings = 0; settings < 5; settings++) begin
      case (settings)
        0: begin write_cfg(CFG_HEAD_MARK, 32'hffffffff); write_cfg(CFG_MAX_LEN, 32'd0); end
        1: begin write_cfg(CFG_HEAD_MARK, 32'h0); write_cfg(CFG_MAX_LEN, 32'hffff); end
        2: begin write_cfg(CFG_HEAD_MARK, $urandom); write_cfg(CFG_MAX_LEN, 32'd12); end
        3: begin write_cfg(CFG_HEAD_MARK, 32'h30316364); write_cfg(CFG_MAX_LEN, 32'd40); end
        default: begin
          write_cfg(CFG_MAX_LEN, 32'd20);
          calm = 1;
        end
      endcase
      while (items_sent < 380 * (settings + 1) + 60) begin
        flaw = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
        blen = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
               16'($urandom_range(0, max_len_cfg < 24 ? max_len_cfg : 24));
        if (max_len_cfg == 16'hffff && blen > 40) blen = 40;
        if (flaw == 6) blen = (max_len_cfg == 16'hffff) ? 16'd3 : max_len_cfg + 16'd1;
        if ($urandom_range(0, 19) == 0) send_byte(8'($urandom));
        else send_packet(flaw, 4'($urandom_range(0, 4)), blen);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/vvpd_pkg.sv
rtl/vvpd_parse.sv
rtl/vvpd_queue.sv
rtl/vehicle_video_packet_deframer.sv
bench/testbench.sv
